>>> sv/tlv_pkg.sv
// Package for the TLV tag value extractor: parser phase type, result record,
// register indexes and field widths. No dependencies.
`default_nettype none

package tlv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WANTED_TAG   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_CAPACITY = 1'b1;

  // Result kinds
  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_DELIVER = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] value_byte;
    logic             found;
    logic [WordW-1:0] value_length;
    logic             truncated;
    logic             last;
  } tlv_res_t;

endpackage

`default_nettype wire

>>> sv/tlv_if.sv
// Valid/ready channel interfaces for the TLV extractor: byte input and result output.
// Depends on tlv_pkg for field widths.
`default_nettype none

interface tlv_in_if;
  import tlv_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tlv_out_if;
  import tlv_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ByteW-1:0] value_byte;
  logic             found;
  logic [WordW-1:0] value_length;
  logic             truncated;
  logic             last;

  modport source (output valid, output kind, output value_byte, output found,
                  output value_length, output truncated, output last, input ready);
  modport sink   (input valid, input kind, input value_byte, input found,
                  input value_length, input truncated, input last, output ready);
endinterface

`default_nettype wire

>>> sv/tlv_tag_value_extractor.sv
// Channel    Dir  Payload                                              Transfer
// in_i       in   data_byte[7:0], end_of_buffer                        valid & ready
// out_o      out  kind, value_byte, found, value_length, truncated,    valid & ready
//                 last
// cfg        in   cfg_idx_i, cfg_data_i[15:0]                          cfg_we_i
//
// One byte is taken per cycle while in_i.ready is high; the parser state updates
// at the transfer edge. Results go to a 4-entry queue and leave one per cycle
// while out_o.ready is high; an end-of-buffer value byte pushes two results.
// in_i.ready is high while the queue holds at most two results.
// Reset: parser in header phase, queue empty, wanted_tag 0, out_capacity 65535.
// Depends on tlv_pkg and tlv_if.
`default_nettype none

module tlv_tag_value_extractor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tlv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tlv_pkg::WordW-1:0]   cfg_data_i,
  tlv_in_if.sink                           in_i,
  tlv_out_if.source                        out_o
);
  import tlv_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Configuration registers
  logic [WordW-1:0] wanted_tag_q, out_capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_tag_q   <= '0;
      out_capacity_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WANTED_TAG:   wanted_tag_q   <= cfg_data_i;
        CFG_OUT_CAPACITY: out_capacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser state
  phase_e           phase_q, phase_d;
  logic [1:0]       hc_q, hc_d;
  logic [WordW-1:0] tag_q, tag_d, len_q, len_d, left_q, left_d, mlen_q, mlen_d;
  logic             seen_q, seen_d;

  logic accept;
  logic [WordW-1:0] hdr_len, left_dec;
  logic             hdr_match;

  // Result queue
  tlv_res_t         q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign in_i.ready = (cnt_q <= QCntW'(QDepth - 2));
  assign accept     = in_i.valid && in_i.ready;

  assign hdr_len   = {len_q[ByteW-1:0], in_i.data_byte};
  assign hdr_match = (tag_q == wanted_tag_q) && (hdr_len <= out_capacity_q);
  assign left_dec  = left_q - WordW'(1);

  // Next-state logic for the parser
  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    tag_d   = tag_q;
    len_d   = len_q;
    left_d  = left_q;
    seen_d  = seen_q;
    mlen_d  = mlen_q;
    case (phase_q)
      PH_HEADER: begin
        hc_d = hc_q + 2'd1;
        if (!hc_q[1]) begin
          tag_d = {tag_q[ByteW-1:0], in_i.data_byte};
        end else begin
          len_d = hdr_len;
        end
        if (hc_q == 2'd3) begin
          left_d = hdr_len;
          if (hdr_match) begin
            seen_d  = 1'b1;
            mlen_d  = hdr_len;
            phase_d = (hdr_len == '0) ? PH_DONE : PH_DELIVER;
          end else begin
            phase_d = (hdr_len == '0) ? PH_HEADER : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        left_d = left_dec;
        if (left_dec == '0) phase_d = PH_HEADER;
      end
      PH_DELIVER: begin
        left_d = left_dec;
        if (left_dec == '0) phase_d = PH_DONE;
      end
      default: ;
    endcase
  end

  // Result items for the byte being taken
  tlv_res_t val_res, sum_res, first_res;
  logic     val_vld, sum_vld;

  always_comb begin
    val_vld = (phase_q == PH_DELIVER);
    sum_vld = in_i.end_of_buffer;

    val_res            = '0;
    val_res.kind       = KIND_VALUE;
    val_res.value_byte = in_i.data_byte;
    val_res.last       = !in_i.end_of_buffer;

    sum_res              = '0;
    sum_res.kind         = KIND_SUMMARY;
    sum_res.found        = seen_d;
    sum_res.value_length = seen_d ? mlen_d : '0;
    sum_res.truncated    = seen_d && (phase_d == PH_DELIVER);
    sum_res.last         = 1'b1;

    first_res = val_vld ? val_res : sum_res;
  end

  // Parser registers: end of buffer returns the parser to its reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q    <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      seen_q  <= 1'b0;
      mlen_q  <= '0;
    end else if (accept) begin
      if (in_i.end_of_buffer) begin
        phase_q <= PH_HEADER;
        hc_q    <= '0;
        tag_q   <= '0;
        len_q   <= '0;
        left_q  <= '0;
        seen_q  <= 1'b0;
        mlen_q  <= '0;
      end else begin
        phase_q <= phase_d;
        hc_q    <= hc_d;
        tag_q   <= tag_d;
        len_q   <= len_d;
        left_q  <= left_d;
        seen_q  <= seen_d;
        mlen_q  <= mlen_d;
      end
    end
  end

  // Queue control
  logic             push1, push2, pop;
  logic [QCntW-1:0] n_push;

  assign push1  = accept && (val_vld || sum_vld);
  assign push2  = accept && val_vld && sum_vld;
  assign n_push = push2 ? QCntW'(2) : (push1 ? QCntW'(1) : '0);
  assign pop    = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(n_push);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + n_push - QCntW'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push1) q_mem_q[wr_q] <= first_res;
    if (push2) q_mem_q[wr_q + QPtrW'(1)] <= sum_res;
  end

  // Output channel
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = q_mem_q[rd_q].kind;
  assign out_o.value_byte   = q_mem_q[rd_q].value_byte;
  assign out_o.found        = q_mem_q[rd_q].found;
  assign out_o.value_length = q_mem_q[rd_q].value_length;
  assign out_o.truncated    = q_mem_q[rd_q].truncated;
  assign out_o.last         = q_mem_q[rd_q].last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_skip_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP || phase_q == PH_DELIVER) |-> (left_q != '0))
    else $error("skip or deliver phase with no bytes left");

  a_deliver_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DELIVER || phase_q == PH_DONE) |-> seen_q)
    else $error("deliver or done phase without a match");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_SUMMARY) |-> out_o.last)
    else $error("summary result not marked last");

  a_eob_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.end_of_buffer) |=> (phase_q == PH_HEADER && hc_q == '0 && !seen_q))
    else $error("parser not cleared after end of buffer");
`endif

endmodule

`default_nettype wire

>>> bench/tlv_extract_checker.sv
// Checker for the TLV tag value extractor: tracks register writes, predicts the
// results of every accepted byte and compares them with the result channel.
// Depends on tlv_pkg and the tlv_in_if / tlv_out_if interfaces.

module tlv_extract_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlv_pkg::WordW-1:0]   cfg_data_i,
  tlv_in_if                           byte_ch,
  tlv_out_if                          res_ch,
  output int                          error_count,
  output int                          pending_count
);
  import tlv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [WordW-1:0] wanted_tag;
  logic [WordW-1:0] out_capacity;

  // Parser copy
  phase_e           parse_phase;
  logic [1:0]       hdr_count;
  logic [WordW-1:0] rec_tag;
  logic [WordW-1:0] rec_len;
  logic [WordW-1:0] bytes_left;
  logic             match_seen;
  logic [WordW-1:0] match_len;

  // Results owed by the block, oldest first
  tlv_res_t owed_results[$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic restart_parse();
    parse_phase = PH_HEADER;
    hdr_count   = '0;
    rec_tag     = '0;
    rec_len     = '0;
    bytes_left  = '0;
    match_seen  = 1'b0;
    match_len   = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  tlv check: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Advance the parser by one buffer byte and queue the results it causes
  task automatic parse_tlv_byte(input logic [ByteW-1:0] b, input logic eob);
    tlv_res_t value_res;
    tlv_res_t summary_res;
    logic     has_value;
    value_res   = '0;
    summary_res = '0;
    has_value   = 1'b0;
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_count < 2'd2) rec_tag = {rec_tag[7:0], b};
        else rec_len = {rec_len[7:0], b};
        hdr_count = hdr_count + 2'd1;
        // header complete: decide between match and skip
        if (hdr_count == 2'd0) begin
          bytes_left = rec_len;
          if (rec_tag == wanted_tag && rec_len <= out_capacity) begin
            match_seen  = 1'b1;
            match_len   = rec_len;
            parse_phase = (rec_len == '0) ? PH_DONE : PH_DELIVER;
          end else begin
            parse_phase = (rec_len == '0) ? PH_HEADER : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) parse_phase = PH_HEADER;
      end
      PH_DELIVER: begin
        has_value            = 1'b1;
        value_res.kind       = KIND_VALUE;
        value_res.value_byte = b;
        bytes_left           = bytes_left - 1'b1;
        if (bytes_left == '0) parse_phase = PH_DONE;
      end
      default: ;
    endcase

    if (has_value) begin
      value_res.last = !eob;
      owed_results.push_back(value_res);
    end
    // end of buffer: summary, then the parser starts over
    if (eob) begin
      summary_res.kind         = KIND_SUMMARY;
      summary_res.found        = match_seen;
      summary_res.value_length = match_seen ? match_len : '0;
      summary_res.truncated    = match_seen && (parse_phase == PH_DELIVER);
      summary_res.last         = 1'b1;
      owed_results.push_back(summary_res);
      restart_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tlv_res_t want;
    if (!rst_ni) begin
      wanted_tag   = '0;
      out_capacity = '1;
      restart_parse();
      owed_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WANTED_TAG) wanted_tag = cfg_data_i;
        else if (cfg_idx_i == CFG_OUT_CAPACITY) out_capacity = cfg_data_i;
      end
      if (byte_ch.valid && byte_ch.ready)
        parse_tlv_byte(byte_ch.data_byte, byte_ch.end_of_buffer);
      // result transfer: compare with the oldest owed result
      if (res_ch.valid && res_ch.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = owed_results.pop_front();
          check_field("kind", want.kind, res_ch.kind);
          check_field("value_byte", want.value_byte, res_ch.value_byte);
          check_field("found", want.found, res_ch.found);
          check_field("value_length", want.value_length, res_ch.value_length);
          check_field("truncated", want.truncated, res_ch.truncated);
          check_field("last", want.last, res_ch.last);
        end
      end
    end
    pending_count = owed_results.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the TLV tag value extractor bench: clock, reset, register writes,
// byte stimulus, result back-pressure and the verdict.
// Depends on tlv_pkg, tlv_if, tlv_tag_value_extractor and tlv_extract_checker.

module testbench;
  import tlv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseBytes  = 300;
  localparam int HoldCycles  = 80;
  localparam int SettleCycles = 8;
  localparam int IdleLimit   = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_data;

  int flaws;
  int pending;

  tlv_in_if  byte_ch ();
  tlv_out_if res_ch ();

  tlv_tag_value_extractor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (byte_ch),
    .out_o      (res_ch)
  );

  tlv_extract_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .byte_ch       (byte_ch),
    .res_ch        (res_ch),
    .error_count   (flaws),
    .pending_count (pending)
  );

  // Current register settings, used to aim records at the wanted tag
  logic [WordW-1:0] tag_setting;
  logic [WordW-1:0] cap_setting;

  logic [ByteW-1:0] frame_q[$];
  int               phase_bytes;
  logic             hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [WordW-1:0] tag, input logic [WordW-1:0] cap);
    write_reg(CFG_WANTED_TAG, tag);
    write_reg(CFG_OUT_CAPACITY, cap);
    cfg_we      <= 1'b0;
    tag_setting = tag;
    cap_setting = cap;
  endtask

  // Stop offering and wait until every owed result has left the block;
  // the owed count is sampled mid-cycle, after the checker has settled
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eob, input logic burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (!byte_ch.ready);
    phase_bytes++;
  endtask

  task automatic send_frame(input logic burst);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, burst);
  endtask

  // Random buffer: mostly well-formed records aimed at the wanted tag, some noise
  task automatic fill_frame();
    int               n_rec;
    int               body;
    logic [WordW-1:0] tag;
    logic [WordW-1:0] len;
    frame_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      n_rec = $urandom_range(1, 4);
      for (int i = 0; i < n_rec; i++) begin
        case ($urandom_range(0, 3))
          0:       tag = WordW'($urandom_range(0, 65535));
          1:       tag = tag_setting ^ (16'h0001 << $urandom_range(0, 15));
          default: tag = tag_setting;
        endcase
        case ($urandom_range(0, 9))
          0:       len = cap_setting;
          1:       len = (cap_setting == 16'hFFFF) ? cap_setting : cap_setting + 16'd1;
          2:       len = WordW'($urandom_range(0, 65535));
          default: len = WordW'($urandom_range(0, 6));
        endcase
        frame_q.push_back(tag[15:8]);
        frame_q.push_back(tag[7:0]);
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
        // long values are cut short, so the buffer can end inside them
        body = (len > 16'd10) ? $urandom_range(0, 10) : int'(len);
        repeat (body) frame_q.push_back(ByteW'($urandom_range(0, 255)));
        if (body < int'(len)) break;
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) frame_q.push_back(ByteW'($urandom_range(0, 255)));
      // sometimes chop the buffer anywhere, header included
      if ($urandom_range(0, 5) == 0 && frame_q.size() > 1)
        frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
    end
  endtask

  // Result side: random stalls, eager stretches, one long hold-off on request
  initial begin
    int   gap;
    int   run_left;
    logic eager;
    res_ch.ready <= 1'b0;
    run_left = 0;
    eager    = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (run_left == 0) begin
        eager    = ($urandom_range(0, 2) == 0);
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      gap = eager ? 0 : $urandom_range(0, 12);
      if (hold_off_req) begin
        gap          = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer at all
  initial begin
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tlv_tag_value_extractor regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= '0;
    byte_ch.end_of_buffer <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_WANTED_TAG;
    cfg_data              <= '0;
    rst_ni                <= 1'b0;
    hold_off_req          = 1'b0;
    tag_setting           = '0;
    cap_setting           = '1;
    phase_bytes           = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset registers: zero-length match, then a byte after it
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_frame(1'b0);
    drain();

    // Directed, tag FFFF / capacity 2: zero-length skip, oversize skip,
    // match whose last value byte ends the buffer
    program_regs(16'hFFFF, 16'd2);
    frame_q = '{8'h12, 8'h34, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03,
                8'hFF, 8'hFF, 8'h00, 8'h02, 8'hAA, 8'h55};
    send_frame(1'b0);
    // match cut short inside the value
    frame_q = '{8'hFF, 8'hFF, 8'h00, 8'h02, 8'h80};
    send_frame(1'b0);
    // header cut short
    frame_q = '{8'hFF, 8'h7F};
    send_frame(1'b0);

    // Random phases over several register settings, extremes included
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       program_regs(WordW'($urandom_range(0, 65535)), 16'hFFFF);
        1:       program_regs(16'hFFFF, 16'h0000);
        2:       program_regs(WordW'($urandom_range(0, 65535)), 16'd4);
        3:       program_regs(16'h0000, 16'd1);
        4:       program_regs(WordW'($urandom_range(0, 65535)), WordW'($urandom_range(0, 10)));
        default: program_regs(WordW'($urandom_range(0, 65535)),
                              WordW'($urandom_range(0, 65535)));
      endcase
      phase_bytes = 0;
      // back-pressure: result side holds off while a long match streams in
      if (p == 0) begin
        hold_off_req = 1'b1;
        frame_q = '{tag_setting[15:8], tag_setting[7:0], 8'h00, 8'h0C};
        repeat (12) frame_q.push_back(ByteW'($urandom_range(0, 255)));
        send_frame(1'b1);
      end
      while (phase_bytes < PhaseBytes) begin
        fill_frame();
        send_frame($urandom_range(0, 3) == 0);
      end
    end

    drain();
    if (flaws == 0 && pending == 0) begin
      $display("tlv_tag_value_extractor regression: pass");
    end else begin
      $display("tlv_tag_value_extractor regression: fail");
    end
    $finish;
  end

endmodule
